FILE: src/tags_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tags_pkg;

  localparam int COUNT_W = 10;
  localparam int MEAN_W = 12;
  localparam int LEN_W = 8;
  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SAMPLES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SAMPLES = 8'd1;

  localparam logic [COUNT_W-1:0] MIN_SAMPLES_RESET = 10'd200;
  localparam logic [COUNT_W-1:0] MAX_SAMPLES_RESET = 10'd1000;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 8'd10;

  localparam logic [MEAN_W-1:0] WIN_X_HIGH = 12'd3725;
  localparam logic [MEAN_W-1:0] WIN_X_LOW = 12'd1760;
  localparam logic [MEAN_W-1:0] WIN_Y_HIGH = 12'd3600;
  localparam logic [MEAN_W-1:0] WIN_Y_LOW = 12'd490;
  localparam logic [MEAN_W-1:0] COL_T0 = 12'd3240;
  localparam logic [MEAN_W-1:0] COL_T1 = 12'd2740;
  localparam logic [MEAN_W-1:0] COL_T2 = 12'd2255;
  localparam logic [MEAN_W-1:0] ROW_T0 = 12'd2830;
  localparam logic [MEAN_W-1:0] ROW_T1 = 12'd2040;
  localparam logic [MEAN_W-1:0] ROW_T2 = 12'd1230;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_DIVIDE,
    ST_WAIT
  } tags_state_t;

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_out;
  } tags_cmd_t;

  typedef struct packed {
    logic touch_done;
  } tags_status_t;

  // 10 + row*40 + col*10, at most 160
  function automatic logic [LEN_W-1:0] grid_value(input logic [1:0] row,
                                                   input logic [1:0] col);
    logic [LEN_W-1:0] r;
    r = 8'd10 + ({6'd0, row} * 8'd40) + ({6'd0, col} * 8'd10);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/tags_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tags_ctrl #(
  parameter int SUM_W = 22
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  out_stall,
  input  wire tags_pkg::tags_status_t status,
  output logic                       in_stall,
  output logic                       out_valid,
  output tags_pkg::tags_cmd_t        cmd
);

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  tags_pkg::tags_state_t state, state_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      tags_pkg::ST_ACCEPT: begin
        if (in_valid && status.touch_done) state_next = tags_pkg::ST_DIVIDE;
      end
      tags_pkg::ST_DIVIDE: begin
        if (step_cnt == '0) state_next = tags_pkg::ST_WAIT;
      end
      tags_pkg::ST_WAIT: begin
        if (out_free) state_next = tags_pkg::ST_ACCEPT;
      end
      default: state_next = tags_pkg::ST_ACCEPT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    step_cnt_next = step_cnt;
    case (state)
      tags_pkg::ST_ACCEPT: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
        cmd.start_div = in_valid && status.touch_done;
        if (cmd.start_div) step_cnt_next = CNT_W'(SUM_W - 1);
      end
      tags_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_cnt_next = step_cnt - 1'b1;
      end
      tags_pkg::ST_WAIT: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // hold the result until the far side takes it
  assign out_valid_next = cmd.load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tags_pkg::ST_ACCEPT;
      step_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step_cnt <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/tags_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tags_datapath #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire tags_pkg::tags_cmd_t                  cmd,
  output tags_pkg::tags_status_t                    status,
  input  wire logic                                 cfg_we,
  input  wire logic [tags_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tags_pkg::COUNT_W-1:0]         cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]               sample_x,
  input  wire logic [SAMPLE_BITS-1:0]               sample_y,
  input  wire logic                                 pen_down,
  output logic [tags_pkg::MEAN_W-1:0]               mean_x,
  output logic [tags_pkg::MEAN_W-1:0]               mean_y,
  output logic                                      hit,
  output logic [tags_pkg::LEN_W-1:0]                length_value
);

  localparam int CW = tags_pkg::COUNT_W;
  localparam int SUM_W = SAMPLE_BITS + CW;
  localparam int QW = (SAMPLE_BITS > tags_pkg::MEAN_W) ? SAMPLE_BITS : tags_pkg::MEAN_W;

  logic [CW-1:0] min_samples, max_samples;
  logic [CW-1:0] sample_count;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [tags_pkg::LEN_W-1:0] current_length;

  logic [CW-1:0] count_new;
  logic [SUM_W-1:0] sum_x_new, sum_y_new;
  logic ended, too_short;

  logic [CW-1:0] divisor;
  logic [SUM_W-1:0] quo_x, quo_y, quo_x_next, quo_y_next;
  logic [CW-1:0] rem_x, rem_y, rem_x_next, rem_y_next;
  logic [CW:0] rem_sh_x, rem_sh_y;
  logic ge_x, ge_y;

  logic [QW-1:0] mx, my;
  logic miss;
  logic [1:0] col, row;
  logic [tags_pkg::LEN_W-1:0] value;

  // touch bookkeeping for the presented sample
  always_comb begin
    count_new = pen_down ? (sample_count + 1'b1) : sample_count;
    sum_x_new = pen_down ? (sum_x + SUM_W'(sample_x)) : sum_x;
    sum_y_new = pen_down ? (sum_y + SUM_W'(sample_y)) : sum_y;
    ended = !pen_down || (count_new >= max_samples);
    too_short = (count_new <= min_samples) || (count_new == '0);
    status.touch_done = ended && !too_short;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples <= tags_pkg::MIN_SAMPLES_RESET;
      max_samples <= tags_pkg::MAX_SAMPLES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tags_pkg::REG_MIN_SAMPLES) min_samples <= cfg_data;
      else if (cfg_index == tags_pkg::REG_MAX_SAMPLES) max_samples <= cfg_data;
    end
  end

  // a finished touch, kept or dropped, clears the sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      sum_x <= '0;
      sum_y <= '0;
    end else if (cmd.accept) begin
      if (ended) begin
        sample_count <= '0;
        sum_x <= '0;
        sum_y <= '0;
      end else begin
        sample_count <= count_new;
        sum_x <= sum_x_new;
        sum_y <= sum_y_new;
      end
    end
  end

  // restoring division, one quotient bit per step for both axes
  always_comb begin
    rem_sh_x = {rem_x, quo_x[SUM_W-1]};
    rem_sh_y = {rem_y, quo_y[SUM_W-1]};
    ge_x = rem_sh_x >= {1'b0, divisor};
    ge_y = rem_sh_y >= {1'b0, divisor};
    rem_x_next = ge_x ? CW'(rem_sh_x - {1'b0, divisor}) : rem_sh_x[CW-1:0];
    rem_y_next = ge_y ? CW'(rem_sh_y - {1'b0, divisor}) : rem_sh_y[CW-1:0];
    quo_x_next = {quo_x[SUM_W-2:0], ge_x};
    quo_y_next = {quo_y[SUM_W-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      divisor <= count_new;
      quo_x <= sum_x_new;
      quo_y <= sum_y_new;
      rem_x <= '0;
      rem_y <= '0;
    end else if (cmd.div_step) begin
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
    end
  end

  // window and grid cell of the means
  always_comb begin
    mx = QW'(quo_x);
    my = QW'(quo_y);
    miss = (mx > QW'(tags_pkg::WIN_X_HIGH)) || (mx < QW'(tags_pkg::WIN_X_LOW)) ||
           (my > QW'(tags_pkg::WIN_Y_HIGH)) || (my < QW'(tags_pkg::WIN_Y_LOW));
    // the low window edge matches no test and falls back to cell zero
    if (mx > QW'(tags_pkg::COL_T0)) col = 2'd0;
    else if (mx > QW'(tags_pkg::COL_T1)) col = 2'd1;
    else if (mx > QW'(tags_pkg::COL_T2)) col = 2'd2;
    else if (mx > QW'(tags_pkg::WIN_X_LOW)) col = 2'd3;
    else col = 2'd0;
    if (my > QW'(tags_pkg::ROW_T0)) row = 2'd0;
    else if (my > QW'(tags_pkg::ROW_T1)) row = 2'd1;
    else if (my > QW'(tags_pkg::ROW_T2)) row = 2'd2;
    else if (my > QW'(tags_pkg::WIN_Y_LOW)) row = 2'd3;
    else row = 2'd0;
    value = miss ? current_length : tags_pkg::grid_value(row, col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_length <= tags_pkg::LENGTH_RESET;
    end else if (cmd.load_out && !miss) begin
      current_length <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mean_x <= mx[tags_pkg::MEAN_W-1:0];
      mean_y <= my[tags_pkg::MEAN_W-1:0];
      hit <= !miss;
      length_value <= value;
    end
  end

endmodule

`default_nettype wire

FILE: src/touch_average_grid_select_core.sv
// Samples that do not end a touch are taken one per cycle.
// A touch-ending sample that keeps its touch starts a restoring divider of
// SAMPLE_BITS+10 steps (22 at the default); the result is offered once the
// division is done and input is stalled meanwhile, and longer while the output waits.
// Reset (rst, synchronous): sums and count cleared, previous value 10,
// min_samples 200, max_samples 1000, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module touch_average_grid_select_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [SAMPLE_BITS-1:0]           sample_x,
  input  wire logic [SAMPLE_BITS-1:0]           sample_y,
  input  wire logic                             pen_down,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [tags_pkg::MEAN_W-1:0]           mean_x,
  output logic [tags_pkg::MEAN_W-1:0]           mean_y,
  output logic                                  hit,
  output logic [tags_pkg::LEN_W-1:0]            length_value,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tags_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tags_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + tags_pkg::COUNT_W;

  tags_pkg::tags_cmd_t cmd;
  tags_pkg::tags_status_t status;

  assign cfg_ready = 1'b1;

  tags_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .out_stall(out_stall),
    .status(status),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .cmd(cmd)
  );

  tags_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_x(sample_x),
    .sample_y(sample_y),
    .pen_down(pen_down),
    .mean_x(mean_x),
    .mean_y(mean_y),
    .hit(hit),
    .length_value(length_value)
  );

  // never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register loaded while a result was pending");

  // no request is taken while the divider runs
  a_stall_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> in_stall)
    else $error("input taken during division");

  // a hit always names a grid value
  a_hit_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (length_value >= 8'd10 && length_value <= 8'd160))
    else $error("grid value out of range");

endmodule

`default_nettype wire

FILE: tb/touch_average_grid_select_core_tb.sv
`timescale 1ns / 1ps

module touch_average_grid_select_core_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [tags_pkg::MEAN_W-1:0] mx;
    logic [tags_pkg::MEAN_W-1:0] my;
    logic                        hit;
    logic [tags_pkg::LEN_W-1:0]  len;
  } grid_result_t;

  class touch_mean_tracker;
    bit [tags_pkg::COUNT_W-1:0] min_lim = tags_pkg::MIN_SAMPLES_RESET;
    bit [tags_pkg::COUNT_W-1:0] max_lim = tags_pkg::MAX_SAMPLES_RESET;
    bit [tags_pkg::COUNT_W-1:0] count;
    bit [21:0]                  sum_x;
    bit [21:0]                  sum_y;
    bit [tags_pkg::LEN_W-1:0]   last_len = tags_pkg::LENGTH_RESET;
    grid_result_t               pending_means[$];
    int                         errors;

    function void set_limit(logic [tags_pkg::CFG_INDEX_W-1:0] idx,
                            logic [tags_pkg::COUNT_W-1:0] val);
      if (idx == tags_pkg::REG_MIN_SAMPLES) min_lim = val;
      else if (idx == tags_pkg::REG_MAX_SAMPLES) max_lim = val;
    endfunction

    function void clear_touch();
      count = '0;
      sum_x = '0;
      sum_y = '0;
    endfunction

    function void take_sample(logic [11:0] x, logic [11:0] y, logic pen);
      bit ended;
      bit [21:0] qx, qy;
      bit [1:0] col, row;
      grid_result_t r;
      if (pen) begin
        sum_x += x;
        sum_y += y;
        count = count + 1'b1;
        ended = (count >= max_lim);
      end else begin
        ended = 1'b1;
      end
      if (!ended) return;
      // short touch: drop it along with its sums
      if (count <= min_lim || count == 0) begin
        clear_touch();
        return;
      end
      qx = sum_x / count;
      qy = sum_y / count;
      clear_touch();
      r.mx = qx[tags_pkg::MEAN_W-1:0];
      r.my = qy[tags_pkg::MEAN_W-1:0];
      if (qx > tags_pkg::WIN_X_HIGH || qx < tags_pkg::WIN_X_LOW ||
          qy > tags_pkg::WIN_Y_HIGH || qy < tags_pkg::WIN_Y_LOW) begin
        r.hit = 1'b0;
        r.len = last_len;
      end else begin
        // a mean sitting exactly on the low window edge falls through to cell 0
        col = (qx > tags_pkg::COL_T0) ? 2'd0 : (qx > tags_pkg::COL_T1) ? 2'd1 :
              (qx > tags_pkg::COL_T2) ? 2'd2 : (qx > tags_pkg::WIN_X_LOW) ? 2'd3 : 2'd0;
        row = (qy > tags_pkg::ROW_T0) ? 2'd0 : (qy > tags_pkg::ROW_T1) ? 2'd1 :
              (qy > tags_pkg::ROW_T2) ? 2'd2 : (qy > tags_pkg::WIN_Y_LOW) ? 2'd3 : 2'd0;
        r.hit = 1'b1;
        r.len = 8'(10 + int'(row) * 40 + int'(col) * 10);
        last_len = r.len;
      end
      pending_means.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_mean(logic [11:0] mx, logic [11:0] my, logic h, logic [7:0] len);
      grid_result_t want;
      if (pending_means.size() == 0) begin
        report_mismatch("touch result with none pending, mean_x", mx, 0);
        return;
      end
      want = pending_means.pop_front();
      if (mx !== want.mx) report_mismatch("mean_x", mx, want.mx);
      if (my !== want.my) report_mismatch("mean_y", my, want.my);
      if (h !== want.hit) report_mismatch("hit", h, want.hit);
      if (len !== want.len) report_mismatch("length_value", len, want.len);
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [11:0]                      sample_x = '0;
  logic [11:0]                      sample_y = '0;
  logic                             pen_down = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [tags_pkg::MEAN_W-1:0]      mean_x;
  logic [tags_pkg::MEAN_W-1:0]      mean_y;
  logic                             hit;
  logic [tags_pkg::LEN_W-1:0]       length_value;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tags_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [tags_pkg::COUNT_W-1:0]     cfg_data = '0;

  touch_mean_tracker board = new();
  int  send_idle = 20;
  int  recv_idle = 63;
  int  requests_sent;
  int  quiet_cycles;
  bit  hold_request;

  touch_average_grid_select_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_x(sample_x),
    .sample_y(sample_y),
    .pen_down(pen_down),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mean_x(mean_x),
    .mean_y(mean_y),
    .hit(hit),
    .length_value(length_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_mean(mean_x, mean_y, hit, length_value);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_now;
    forever begin
      @(posedge clk);
      hold_now = hold_request;
      @(negedge clk);
      if (hold_now) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  // entered and left at a falling edge
  task automatic send_sample(input logic [11:0] x, input logic [11:0] y, input logic pen);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_x = x;
    sample_y = y;
    pen_down = pen;
    do @(posedge clk); while (in_stall);
    board.take_sample(x, y, pen);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limits(input logic [tags_pkg::COUNT_W-1:0] lo,
                              input logic [tags_pkg::COUNT_W-1:0] hi);
    for (int r = 0; r < 2; r++) begin
      cfg_valid = 1'b1;
      cfg_index = r ? tags_pkg::REG_MAX_SAMPLES : tags_pkg::REG_MIN_SAMPLES;
      cfg_data = r ? hi : lo;
      do @(posedge clk); while (!cfg_ready);
      board.set_limit(cfg_index, cfg_data);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  function automatic logic [11:0] reading_near(int centre, int spread);
    int v;
    v = centre - spread + int'($urandom_range(2 * spread));
    if (v < 0) v = 0;
    else if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic send_touch(input int n, input bit lift);
    int x_edges[5] = '{1760, 2255, 2740, 3240, 3725};
    int y_edges[5] = '{490, 1230, 2040, 2830, 3600};
    int cx, cy, spread;
    cx = $urandom_range(3900, 1600);
    cy = $urandom_range(3800, 300);
    spread = $urandom_range(300);
    case ($urandom_range(5))
      0: begin
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
      end
      1: begin
        // park the touch on a grid boundary, give or take one
        cx = x_edges[$urandom_range(4)] - 1 + int'($urandom_range(2));
        cy = y_edges[$urandom_range(4)] - 1 + int'($urandom_range(2));
        spread = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        send_sample(12'($urandom), 12'($urandom), 1'b1);
      else
        send_sample(reading_near(cx, spread), reading_near(cy, spread), 1'b1);
    end
    if (lift) send_sample(12'($urandom), 12'($urandom), 1'b0);
  endtask

  initial begin
    int phase_end, span;
    logic [tags_pkg::COUNT_W-1:0] lo, hi;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // release with nothing gathered
    send_sample(12'd0, 12'd0, 1'b0);
    settle();

    // every pen-down sample is a touch of its own: exact means on the window and grid edges
    write_limits(10'd0, 10'd0);
    send_sample(12'd0, 12'd0, 1'b1);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_sample(12'd1760, 12'd490, 1'b1);
    send_sample(12'd1761, 12'd491, 1'b1);
    send_sample(12'd1759, 12'd2000, 1'b1);
    send_sample(12'd3726, 12'd2000, 1'b1);
    send_sample(12'd2000, 12'd489, 1'b1);
    send_sample(12'd2000, 12'd3601, 1'b1);
    send_sample(12'd3725, 12'd3600, 1'b1);
    send_sample(12'd2255, 12'd1230, 1'b1);
    send_sample(12'd2256, 12'd1231, 1'b1);
    send_sample(12'd2740, 12'd2040, 1'b1);
    send_sample(12'd2741, 12'd2041, 1'b1);
    send_sample(12'd3240, 12'd2830, 1'b1);
    send_sample(12'd3241, 12'd2831, 1'b1);
    send_sample(12'hAAA, 12'h555, 1'b1);
    send_sample(12'h555, 12'hAAA, 1'b0);
    settle();

    // limit not above the minimum: the held touch is dropped
    write_limits(10'd3, 10'd3);
    send_touch(3, 1'b1);
    settle();

    // short touch, then a valid one that must not see its sums
    write_limits(10'd2, 10'd9);
    send_sample(12'd4000, 12'd4000, 1'b1);
    send_sample(12'd4000, 12'd4000, 1'b1);
    send_sample(12'd0, 12'd0, 1'b0);
    send_sample(12'd2000, 12'd1000, 1'b1);
    send_sample(12'd2002, 12'd1001, 1'b1);
    send_sample(12'd2004, 12'd1003, 1'b1);
    send_sample(12'd0, 12'd0, 1'b0);
    settle();

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin lo = 10'd1;    hi = 10'd1023; span = 24; end
        1: begin lo = 10'd1023; hi = 10'd1023; span = 12; end
        2: begin lo = 10'd0;    hi = 10'd1;    span = 3;  end
        3: begin lo = 10'd40;   hi = 10'd60;   span = 70; end
        default: begin
          lo = 10'($urandom_range(6));
          hi = 10'($urandom_range(18, 1));
          span = int'(hi) + 3;
        end
      endcase
      if (ph == 4) begin
        send_idle = 63;
        recv_idle = 20;
      end
      if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_limits(lo, hi);
      // every pen-down request yields a result here, so a long hold-off backs the block up
      if (ph == 2) hold_request = 1'b1;
      phase_end = requests_sent + 62;
      while (requests_sent < phase_end)
        send_touch($urandom_range(span), $urandom_range(9) < 8);
      settle();
    end

    if (board.errors == 0 && board.pending_means.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
